[hw/rtl/swt_pkg.sv]
// Shared types and constants for the shell word tokenizer.
// No dependencies; used by every module of the block.
package swt_pkg;

  localparam int MAX_WORD_LEN = 4096;
  localparam int LEN_CAP_INT = (MAX_WORD_LEN - 1 > 4095) ? 4095 : MAX_WORD_LEN - 1;
  localparam logic [11:0] LEN_CAP = 12'(LEN_CAP_INT);
  localparam logic [7:0] WORD_COUNT_MAX = 8'd255;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_QMARK = 8'h3f;

  localparam int FLAG_ESC = 0;
  localparam int FLAG_QUOTE = 1;
  localparam int FLAG_WILD = 2;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_SKIP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CONTENT  = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_LINE_END = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  content;
    logic [7:0]  word_number;
    logic [11:0] word_length;
    logic [2:0]  flags;
    logic [7:0]  words_in_line;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_content(logic [7:0] b, logic [7:0] wn);
    res_t r;
    r.kind = KIND_CONTENT;
    r.content = b;
    r.word_number = wn;
    r.word_length = 12'd0;
    r.flags = 3'd0;
    r.words_in_line = 8'd0;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_word_end(logic [7:0] wn, logic [11:0] len, logic [2:0] fl);
    res_t r;
    r.kind = KIND_WORD_END;
    r.content = 8'd0;
    r.word_number = wn;
    r.word_length = len;
    r.flags = fl;
    r.words_in_line = 8'd0;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_line_end(logic [7:0] wil);
    res_t r;
    r.kind = KIND_LINE_END;
    r.content = 8'd0;
    r.word_number = 8'd0;
    r.word_length = 12'd0;
    r.flags = 3'd0;
    r.words_in_line = wil;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] sat_inc8(logic [7:0] v);
    return (v < WORD_COUNT_MAX) ? 8'(v + 8'd1) : v;
  endfunction

endpackage

[hw/rtl/swt_scan.sv]
// Input register, scan state and per-byte result generation.
// Depends on swt_pkg; pushes up to two results per byte into swt_queue.
module swt_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        text_byte,
  input  logic              room,
  output swt_pkg::push_t    push
);

  logic                  hold_valid;
  logic [7:0]            hold_byte;
  logic [7:0]            word_limit;
  swt_pkg::mode_t        scan_mode, scan_mode_next;
  logic                  escape_pending, escape_pending_next;
  logic [2:0]            word_flags, word_flags_next;
  logic [11:0]           length_count, length_count_next;
  logic [7:0]            word_count, word_count_next;
  logic                  fire;
  logic [7:0]            end_ch;
  logic [2:0]            wild;
  logic [11:0]           len_inc;
  swt_pkg::res_t         r0, r1;
  logic [1:0]            count;

  assign fire = hold_valid && room;
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_byte <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_limit <= 8'd0;
    end else if (cfg_wr_en) begin
      word_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= swt_pkg::MODE_IDLE;
      escape_pending <= 1'b0;
      word_flags <= 3'd0;
      length_count <= 12'd0;
      word_count <= 8'd0;
    end else if (fire) begin
      scan_mode <= scan_mode_next;
      escape_pending <= escape_pending_next;
      word_flags <= word_flags_next;
      length_count <= length_count_next;
      word_count <= word_count_next;
    end
  end

  always_comb begin
    end_ch = (scan_mode == swt_pkg::MODE_QUOTED) ? swt_pkg::CH_QUOTE : swt_pkg::CH_SPACE;
    wild = 3'd0;
    wild[swt_pkg::FLAG_WILD] = (hold_byte == swt_pkg::CH_STAR) ||
                               (hold_byte == swt_pkg::CH_QMARK);
    len_inc = (length_count < swt_pkg::LEN_CAP) ? 12'(length_count + 12'd1) : length_count;

    scan_mode_next = scan_mode;
    escape_pending_next = escape_pending;
    word_flags_next = word_flags;
    length_count_next = length_count;
    word_count_next = word_count;
    count = 2'd0;
    r0 = swt_pkg::mk_content(hold_byte, word_count);
    r1 = swt_pkg::mk_line_end(word_count);

    if (hold_byte == swt_pkg::CH_NUL) begin
      if (scan_mode == swt_pkg::MODE_PLAIN || scan_mode == swt_pkg::MODE_QUOTED) begin
        r0 = swt_pkg::mk_word_end(word_count, length_count, word_flags);
        r1 = swt_pkg::mk_line_end(swt_pkg::sat_inc8(word_count));
        count = 2'd2;
      end else begin
        r0 = swt_pkg::mk_line_end(word_count);
        count = 2'd1;
      end
      scan_mode_next = swt_pkg::MODE_IDLE;
      escape_pending_next = 1'b0;
      word_flags_next = 3'd0;
      length_count_next = 12'd0;
      word_count_next = 8'd0;
    end else begin
      unique case (scan_mode)
        swt_pkg::MODE_SKIP: begin
        end
        swt_pkg::MODE_IDLE: begin
          if (hold_byte == swt_pkg::CH_SPACE || hold_byte == swt_pkg::CH_TAB) begin
          end else if (word_limit != 8'd0 && word_count >= word_limit) begin
            scan_mode_next = swt_pkg::MODE_SKIP;
          end else if (hold_byte == swt_pkg::CH_QUOTE) begin
            scan_mode_next = swt_pkg::MODE_QUOTED;
            word_flags_next = 3'd1 << swt_pkg::FLAG_QUOTE;
          end else if (hold_byte == swt_pkg::CH_BSLASH) begin
            scan_mode_next = swt_pkg::MODE_PLAIN;
            word_flags_next = 3'd1 << swt_pkg::FLAG_ESC;
            escape_pending_next = 1'b1;
          end else begin
            scan_mode_next = swt_pkg::MODE_PLAIN;
            word_flags_next = word_flags | wild;
            length_count_next = len_inc;
            count = 2'd1;
          end
        end
        default: begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            word_flags_next = word_flags | wild;
            length_count_next = len_inc;
            count = 2'd1;
          end else if (hold_byte == swt_pkg::CH_BSLASH) begin
            word_flags_next = word_flags | (3'd1 << swt_pkg::FLAG_ESC);
            escape_pending_next = 1'b1;
          end else if (hold_byte == end_ch) begin
            r0 = swt_pkg::mk_word_end(word_count, length_count, word_flags);
            count = 2'd1;
            word_count_next = swt_pkg::sat_inc8(word_count);
            scan_mode_next = swt_pkg::MODE_IDLE;
            escape_pending_next = 1'b0;
            word_flags_next = 3'd0;
            length_count_next = 12'd0;
          end else begin
            word_flags_next = word_flags | wild;
            length_count_next = len_inc;
            count = 2'd1;
          end
        end
      endcase
    end

    r0.last = (count == 2'd1);
    r1.last = 1'b1;
    push.count = fire ? count : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

endmodule

[hw/rtl/swt_queue.sv]
// Result queue: per cycle, up to two results in, one beat out if out_ready.
// Depends on swt_pkg; fed by swt_scan.
module swt_queue (
  input  logic            clk,
  input  logic            rst,
  input  swt_pkg::push_t  push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output swt_pkg::res_t   head,
  output logic [swt_pkg::QUEUE_AW:0] level
);

  swt_pkg::res_t                   entries [swt_pkg::QUEUE_DEPTH];
  logic [swt_pkg::QUEUE_AW-1:0]    wptr, rptr;
  logic [swt_pkg::QUEUE_AW:0]      level_next;
  logic                            pop;
  logic [swt_pkg::QUEUE_AW-1:0]    wptr1;

  assign pop = out_valid && out_ready;
  assign out_valid = (level != '0);
  assign head = entries[rptr];
  assign room = (level <= (swt_pkg::QUEUE_AW + 1)'(swt_pkg::QUEUE_DEPTH - 2));
  assign wptr1 = wptr + 1'b1;
  assign level_next = level + (swt_pkg::QUEUE_AW + 1)'(push.count)
                      - (swt_pkg::QUEUE_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      level <= '0;
    end else begin
      wptr <= wptr + swt_pkg::QUEUE_AW'(push.count);
      rptr <= rptr + swt_pkg::QUEUE_AW'(pop);
      level <= level_next;
    end
    if (push.count != 2'd0) begin
      entries[wptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wptr1] <= push.r1;
    end
  end

endmodule

[hw/rtl/shell_word_tokenizer_top.sv]
// An accepted byte is held in the input register and scanned; its result beats go
// to the result queue. Throughput: one byte per cycle while the queue has room; a
// line end that closes a word gives two beats, one per cycle while out_ready is
// high, through a four-entry result queue. Reset (rst, synchronous) returns the
// scan state to between words, clears word_limit and empties the queue.
module shell_word_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  item_kind,
  output logic [7:0]  content,
  output logic [7:0]  word_number,
  output logic [11:0] word_length,
  output logic        had_escape,
  output logic        was_quoted,
  output logic        has_wildcard,
  output logic [7:0]  words_in_line,
  output logic        last_of_run
);

  swt_pkg::push_t                push;
  swt_pkg::res_t                 head;
  logic                          room;
  logic [swt_pkg::QUEUE_AW:0]    level;

  swt_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .room        (room),
    .push        (push)
  );

  swt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .level     (level)
  );

  assign item_kind = head.kind;
  assign content = head.content;
  assign word_number = head.word_number;
  assign word_length = head.word_length;
  assign had_escape = head.flags[swt_pkg::FLAG_ESC];
  assign was_quoted = head.flags[swt_pkg::FLAG_QUOTE];
  assign has_wildcard = head.flags[swt_pkg::FLAG_WILD];
  assign words_in_line = head.words_in_line;
  assign last_of_run = head.last;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= (swt_pkg::QUEUE_AW + 1)'(swt_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_pair_on_line_end: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.r1.kind == swt_pkg::KIND_LINE_END &&
                           push.r0.kind == swt_pkg::KIND_WORD_END)
    else $error("two results pushed for a byte other than a word-closing line end");

  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == swt_pkg::KIND_LINE_END |-> last_of_run)
    else $error("line end beat not marked last of run");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !room |-> push.count == 2'd0)
    else $error("result pushed without queue room");
`endif

endmodule
